[sv/q15dt_pkg.sv]
// ----------------------------------------------------------------------------
// q15dt_pkg
// Shared types, constants and helpers of the Q15 probability to decimal text
// unit.
// ----------------------------------------------------------------------------
`default_nettype none

package q15dt_pkg;

    // ASCII characters that make up the text
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_POINT = 8'h2E;

    // Five-place rounding: (3125*r + 512) >> 10, tie fix when r mod 2048 == 512
    localparam logic [11:0] ROUND_MUL   = 12'd3125;
    localparam logic [9:0]  ROUND_BIAS  = 10'd512;
    localparam int          ROUND_SHIFT = 10;
    localparam logic [10:0] TIE_PATTERN = 11'd512;

    // floor(x/100) = (x * 167773) >> 24, exact for x below 199729
    localparam logic [17:0] RECIP_100       = 18'd167773;
    localparam int          RECIP_100_SHIFT = 24;

    // Byte positions within one run of text
    localparam logic [2:0] POS_SPACE = 3'd0;
    localparam logic [2:0] POS_INT   = 3'd1;
    localparam logic [2:0] POS_POINT = 3'd2;
    localparam logic [2:0] POS_FRAC0 = 3'd3;

    // One queued value: integer digit, five fraction digits (most significant
    // at index 0) and the position of its final byte
    typedef struct packed {
        logic             int_bit;
        logic [2:0]       last_pos;
        logic [0:4][3:0]  digits;
    } q15dt_entry_t;

    // Split 0..99 into tens and ones: tens = (x * 205) >> 11
    function automatic logic [7:0] digit_pair(input logic [6:0] x);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        logic [6:0]  ones;
        prod     = 15'(x) * 15'd205;
        tens     = prod[14:11];
        tens_x10 = (7'(tens) << 3) + (7'(tens) << 1);
        ones     = x - tens_x10;
        return {tens, ones[3:0]};
    endfunction

endpackage

`default_nettype wire

[sv/q15_probability_to_decimal_text_unit.sv]
// An input passes front-end stages, entry queue and output register to reach m_*.
// Throughput: one character per cycle while m_tready is high and an entry waits;
// a run has 2 to 8 bytes (2 for a zero fraction, 3 plus its digit count else).
// Input side takes one item per cycle until queue and front-end stages are full.
// Reset (aresetn low, synchronous) empties pipeline, queue and output register.
// ----------------------------------------------------------------------------
// q15_probability_to_decimal_text_unit
// Converts a 16-bit Q15 value into its decimal ASCII text, one character per
// transfer, with tlast on the final character.
// ----------------------------------------------------------------------------
`default_nettype none

module q15_probability_to_decimal_text_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,    // [15:0] raw_value
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,    // [7:0] text_byte
    output logic        m_tlast     // last_byte
);
    import q15dt_pkg::*;

    logic         wr_valid, wr_ready;
    logic         rd_valid, rd_ready;
    q15dt_entry_t wr_data, rd_data;

    q15dt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (wr_valid),
        .q_ready  (wr_ready),
        .q_data   (wr_data)
    );

    q15dt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr_data  (wr_data),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_data  (rd_data)
    );

    q15dt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (rd_valid),
        .q_ready  (rd_ready),
        .q_data   (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

[sv/q15dt_front.sv]
// ----------------------------------------------------------------------------
// q15dt_front
// Input side: rounds the fraction to five decimal places and splits it into
// digits over three register stages, then pushes one entry into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module q15dt_front (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_tvalid,
    output logic                      s_tready,
    input  wire  [15:0]               s_tdata,    // [15:0] raw_value
    output logic                      q_valid,
    input  wire                       q_ready,
    output q15dt_pkg::q15dt_entry_t   q_data
);
    import q15dt_pkg::*;

    // Stage valids
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic adv1, adv2, adv3;

    // Stage 1: rounded five-place value
    logic [16:0] five1_reg, five1_next;
    logic        int1_reg, int1_next;
    logic        nz1_reg, nz1_next;

    // Stage 2: value / 100
    logic [16:0] five2_reg, five2_next;
    logic [9:0]  hi2_reg, hi2_next;
    logic        int2_reg, int2_next;
    logic        nz2_reg, nz2_next;

    // Stage 3: low two digits, top digit and value / 100
    logic [6:0]  lo3_reg, lo3_next;
    logic [3:0]  d0_3_reg, d0_3_next;
    logic [9:0]  hi3_reg, hi3_next;
    logic        int3_reg, int3_next;
    logic        nz3_reg, nz3_next;

    logic [14:0] frac;
    logic [26:0] round_prod;
    logic [16:0] five_raw;
    logic [34:0] hi_prod;
    logic [27:0] d0_prod;
    logic [16:0] hi2_x100;
    logic [16:0] lo_wide;
    logic [9:0]  d0_x100;
    logic [9:0]  mid_wide;
    logic [7:0]  mid_pair;
    logic [7:0]  lo_pair;
    logic [0:4][3:0] digs;
    logic [2:0]  frac_last;

    // Pipeline flow: a stage moves when the one after it is empty or moving
    assign adv3     = !v3_reg || q_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;
    assign q_valid  = v3_reg;

    // Stage 1 logic
    assign frac       = s_tdata[14:0];
    assign round_prod = 27'(frac) * 27'(ROUND_MUL) + 27'(ROUND_BIAS);
    assign five_raw   = round_prod[26:ROUND_SHIFT];

    // Stage 2 and 3 logic
    assign hi_prod  = 35'(five1_reg) * 35'(RECIP_100);
    assign hi2_x100 = (17'(hi2_reg) << 6) + (17'(hi2_reg) << 5) + (17'(hi2_reg) << 2);
    assign lo_wide  = five2_reg - hi2_x100;
    assign d0_prod  = 28'(hi2_reg) * 28'(RECIP_100);

    // Final digits, combinational into the queue
    assign d0_x100  = (10'(d0_3_reg) << 6) + (10'(d0_3_reg) << 5) + (10'(d0_3_reg) << 2);
    assign mid_wide = hi3_reg - d0_x100;
    assign mid_pair = digit_pair(mid_wide[6:0]);
    assign lo_pair  = digit_pair(lo3_reg);

    always_comb begin
        digs[0] = d0_3_reg;
        digs[1] = mid_pair[7:4];
        digs[2] = mid_pair[3:0];
        digs[3] = lo_pair[7:4];
        digs[4] = lo_pair[3:0];
        // trailing zeros dropped: last nonzero fraction digit
        priority if (digs[4] != 4'd0) begin
            frac_last = POS_FRAC0 + 3'd4;
        end else if (digs[3] != 4'd0) begin
            frac_last = POS_FRAC0 + 3'd3;
        end else if (digs[2] != 4'd0) begin
            frac_last = POS_FRAC0 + 3'd2;
        end else if (digs[1] != 4'd0) begin
            frac_last = POS_FRAC0 + 3'd1;
        end else begin
            frac_last = POS_FRAC0;
        end
        q_data.int_bit  = int3_reg;
        q_data.digits   = digs;
        q_data.last_pos = nz3_reg ? frac_last : POS_INT;
    end

    // Next-state logic for all stages
    always_comb begin
        v1_next    = adv1 ? s_tvalid : v1_reg;
        v2_next    = adv2 ? v1_reg : v2_reg;
        v3_next    = adv3 ? v2_reg : v3_reg;

        five1_next = five1_reg;
        int1_next  = int1_reg;
        nz1_next   = nz1_reg;
        if (adv1) begin
            five1_next = (frac[10:0] == TIE_PATTERN) ? five_raw - 17'd1 : five_raw;
            int1_next  = s_tdata[15];
            nz1_next   = (frac != 15'd0);
        end

        five2_next = five2_reg;
        hi2_next   = hi2_reg;
        int2_next  = int2_reg;
        nz2_next   = nz2_reg;
        if (adv2) begin
            five2_next = five1_reg;
            hi2_next   = hi_prod[RECIP_100_SHIFT +: 10];
            int2_next  = int1_reg;
            nz2_next   = nz1_reg;
        end

        lo3_next  = lo3_reg;
        d0_3_next = d0_3_reg;
        hi3_next  = hi3_reg;
        int3_next = int3_reg;
        nz3_next  = nz3_reg;
        if (adv3) begin
            lo3_next  = lo_wide[6:0];
            d0_3_next = d0_prod[RECIP_100_SHIFT +: 4];
            hi3_next  = hi2_reg;
            int3_next = int2_reg;
            nz3_next  = nz2_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        five1_reg <= five1_next;
        int1_reg  <= int1_next;
        nz1_reg   <= nz1_next;
        five2_reg <= five2_next;
        hi2_reg   <= hi2_next;
        int2_reg  <= int2_next;
        nz2_reg   <= nz2_next;
        lo3_reg   <= lo3_next;
        d0_3_reg  <= d0_3_next;
        hi3_reg   <= hi3_next;
        int3_reg  <= int3_next;
        nz3_reg   <= nz3_next;
    end

endmodule

`default_nettype wire

[sv/q15dt_fifo.sv]
// ----------------------------------------------------------------------------
// q15dt_fifo
// Short register queue between the digit front end and the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module q15dt_fifo #(
    parameter int DEPTH = 4
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       wr_valid,
    output logic                      wr_ready,
    input  q15dt_pkg::q15dt_entry_t   wr_data,
    output logic                      rd_valid,
    input  wire                       rd_ready,
    output q15dt_pkg::q15dt_entry_t   rd_data
);
    import q15dt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q15dt_entry_t mem_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[sv/q15dt_back.sv]
// ----------------------------------------------------------------------------
// q15dt_back
// Output side: walks the queue head one character per transfer into the
// output register, flags the final character and frees the entry.
// ----------------------------------------------------------------------------
`default_nettype none

module q15dt_back (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       q_valid,
    output logic                      q_ready,
    input  q15dt_pkg::q15dt_entry_t   q_data,
    output logic                      m_tvalid,
    input  wire                       m_tready,
    output logic [7:0]                m_tdata,    // [7:0] text_byte
    output logic                      m_tlast     // last_byte
);
    import q15dt_pkg::*;

    logic [2:0] pos_reg, pos_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic       m_tlast_reg, m_tlast_next;
    logic       load;
    logic       is_last;
    logic [7:0] chr;
    logic [2:0] dig_idx;

    assign load     = q_valid && (!m_tvalid_reg || m_tready);
    assign is_last  = (pos_reg == q_data.last_pos);
    assign q_ready  = load && is_last;
    assign dig_idx  = pos_reg - POS_FRAC0;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Character for the current position
    always_comb begin
        unique case (pos_reg)
            POS_SPACE: chr = CHR_SPACE;
            POS_INT:   chr = CHR_ZERO + 8'(q_data.int_bit);
            POS_POINT: chr = CHR_POINT;
            default:   chr = CHR_ZERO + 8'(q_data.digits[dig_idx]);
        endcase
    end

    // Output register and position counter
    always_comb begin
        pos_next      = pos_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = chr;
            m_tlast_next  = is_last;
            pos_next      = is_last ? POS_SPACE : pos_reg + 3'd1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= POS_SPACE;
            m_tvalid_reg <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule

`default_nettype wire

[sv/q15dt_checker.sv]
// ----------------------------------------------------------------------------
// q15dt_checker
// Port-level checks of the text unit: output hold under stall, run framing
// and no output without an outstanding input.
// ----------------------------------------------------------------------------
`default_nettype none

module q15dt_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire [15:0] s_tdata,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [7:0]  m_tdata,
    input wire        m_tlast
);
    import q15dt_pkg::*;

    logic [2:0] pos_reg, pos_next;
    logic [4:0] pend_reg, pend_next;
    logic       in_xfer, out_xfer, run_done;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;
    assign run_done = out_xfer && m_tlast;

    // Character position within the run and runs still owed
    always_comb begin
        pos_next  = pos_reg;
        pend_next = pend_reg + 5'(in_xfer) - 5'(run_done);
        if (out_xfer) begin
            pos_next = m_tlast ? POS_SPACE : pos_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= POS_SPACE;
            pend_reg <= '0;
        end else begin
            pos_reg  <= pos_next;
            pend_reg <= pend_next;
        end
    end

    // Stalled output holds its character
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // Each run opens with a space that never ends it
    a_space: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && pos_reg == POS_SPACE |-> m_tdata == CHR_SPACE && !m_tlast)
        else $error("run does not open with a space");

    // Third character, when present, is the decimal point
    a_point: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && pos_reg == POS_POINT |-> m_tdata == CHR_POINT && !m_tlast)
        else $error("third character is not a point");

    // No character without an accepted, unfinished input
    a_owed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 5'd0)
        else $error("output without pending input");

endmodule

bind q15_probability_to_decimal_text_unit q15dt_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
